FILE: rtl/core/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants for the lidar frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam logic [7:0]  HEADER_BYTE = 8'h59;
  localparam logic [2:0]  PAYLOAD_LEN = 3'd6;
  localparam logic [15:0] LIMIT_RESET = 16'd12000;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'b001,
    PH_HUNT2 = 3'b010,
    PH_BODY  = 3'b100
  } lfp_phase_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } lfp_byte_t;

  typedef struct packed {
    logic [15:0] held_distance;
    logic [15:0] raw_distance;
    logic        out_of_range;
  } lfp_result_t;

endpackage

FILE: rtl/core/lfp_in_stage.sv
// ----------------------------------------------------------------------------
// lfp_in_stage
// Input register that holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module lfp_in_stage
  import lfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic      step,
  output lfp_byte_t byte_q
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_stall = valid_r && !step;
  assign byte_q   = '{valid: valid_r, data: data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

FILE: rtl/core/lfp_parser.sv
// ----------------------------------------------------------------------------
// lfp_parser
// Header hunt, payload gathering and checksum check for one byte per step.
// ----------------------------------------------------------------------------
module lfp_parser
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] range_limit,
  output logic        res_valid,
  output lfp_result_t res
);

  lfp_phase_t  phase_r, phase_nxt;
  logic [2:0]  count_r, count_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic [15:0] held_r, held_nxt;
  logic [15:0] raw;
  logic        oor;

  assign raw = {hi_r, lo_r};
  assign oor = (raw >= range_limit);

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    sum_nxt   = sum_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    held_nxt  = held_r;
    res_valid = 1'b0;
    if (step) begin
      case (phase_r)
        PH_HUNT2: begin
          if (rx_byte == HEADER_BYTE) begin
            sum_nxt   = sum_r + rx_byte;
            count_nxt = '0;
            phase_nxt = PH_BODY;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
        PH_BODY: begin
          if (count_r < PAYLOAD_LEN) begin
            if (count_r == 3'd0) begin
              lo_nxt = rx_byte;
            end
            if (count_r == 3'd1) begin
              hi_nxt = rx_byte;
            end
            sum_nxt   = sum_r + rx_byte;
            count_nxt = count_r + 3'd1;
          end else begin
            phase_nxt = PH_HUNT1;
            count_nxt = '0;
            if (sum_r == rx_byte) begin
              res_valid = 1'b1;
              if (!oor) begin
                held_nxt = raw;
              end
            end
          end
        end
        default: begin
          if (rx_byte == HEADER_BYTE) begin
            sum_nxt   = rx_byte;
            phase_nxt = PH_HUNT2;
          end else begin
            phase_nxt = PH_HUNT1;
          end
        end
      endcase
    end
  end

  assign res = '{held_distance: held_nxt, raw_distance: raw, out_of_range: oor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT1;
      count_r <= '0;
      sum_r   <= '0;
      held_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      held_r  <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

endmodule

FILE: rtl/core/lfp_out_stage.sv
// ----------------------------------------------------------------------------
// lfp_out_stage
// Result register that holds a finished distance until it is taken.
// ----------------------------------------------------------------------------
module lfp_out_stage
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        res_valid,
  input  lfp_result_t res,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_held_distance,
  output logic [15:0] out_raw_distance,
  output logic        out_out_of_range
);

  logic        valid_r;
  lfp_result_t res_r;

  assign free              = !valid_r || !out_stall;
  assign out_valid         = valid_r;
  assign out_held_distance = res_r.held_distance;
  assign out_raw_distance  = res_r.raw_distance;
  assign out_out_of_range  = res_r.out_of_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && res_valid) begin
      res_r <= res;
    end
  end

endmodule

FILE: rtl/core/lidar_frame_parser.sv
// ----------------------------------------------------------------------------
// lidar_frame_parser
// Serial lidar frame parser: finds the header pair, checks the checksum and
// reports the raw and held distance of every good frame.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_rx_byte
//   out      output     out_valid / out_stall  out_held_distance,
//                                              out_raw_distance, out_out_of_range
//   cfg      input      cfg_wr_en              cfg_wr_data (range limit)
//
// One byte is accepted per cycle while in_stall is low; a result is presented
// once its checksum byte has passed the input register, from which the parser
// reads it, and then the result register, which may wait on out_stall.
// Reset is synchronous and active low; the range limit resets to 12000.
// A stalled result holds the parser, which then stalls the input.
// ----------------------------------------------------------------------------
module lidar_frame_parser
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_held_distance,
  output logic [15:0] out_raw_distance,
  output logic        out_out_of_range,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] limit_r;
  lfp_byte_t   byte_q;
  logic        free;
  logic        step;
  logic        res_valid;
  lfp_result_t res;

  assign step = byte_q.valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  lfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .step       (step),
    .byte_q     (byte_q)
  );

  lfp_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .rx_byte     (byte_q.data),
    .range_limit (limit_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  lfp_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .free              (free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_held_distance (out_held_distance),
    .out_raw_distance  (out_raw_distance),
    .out_out_of_range  (out_out_of_range)
  );

`ifndef SYNTH
  a_res_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> step)
    else $error("Parser produced a result without consuming a byte.");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !step)
    else $error("Parser advanced while the result register was blocked.");

  a_held_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_out_of_range) |-> (out_held_distance == out_raw_distance))
    else $error("Held distance differs from an in-range raw distance.");
`endif

endmodule

FILE: dv/lfp_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfp_frame_checker
// Watches the byte, result and limit ports of the lidar frame parser.
// It follows each accepted byte with its own frame parser, queues the result
// that every good frame should produce and compares the results in order.
// ----------------------------------------------------------------------------
module lfp_frame_checker
  import lfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_held_distance,
  input  logic [15:0] out_raw_distance,
  input  logic        out_out_of_range,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          errors,
  output int          pending
);

  lfp_phase_t  parse_phase;
  logic [2:0]  body_cnt;
  logic [7:0]  sum_acc;
  logic [7:0]  dist_lo;
  logic [7:0]  dist_hi;
  logic [15:0] held_dist;
  logic [15:0] limit_reg;
  lfp_result_t expected_frames[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic parse_byte(input logic [7:0] b);
    lfp_result_t r;
    logic [15:0] raw;
    case (parse_phase)
      PH_HUNT2: begin
        if (b == HEADER_BYTE) begin
          sum_acc     = sum_acc + b;
          body_cnt    = 3'd0;
          parse_phase = PH_BODY;
        end else begin
          parse_phase = PH_HUNT1;
        end
      end
      PH_BODY: begin
        if (body_cnt < PAYLOAD_LEN) begin
          if (body_cnt == 3'd0) dist_lo = b;
          else if (body_cnt == 3'd1) dist_hi = b;
          sum_acc  = sum_acc + b;
          body_cnt = body_cnt + 3'd1;
        end else begin
          parse_phase = PH_HUNT1;
          body_cnt    = 3'd0;
          if (sum_acc == b) begin
            raw = {dist_hi, dist_lo};
            r.out_of_range = (raw >= limit_reg);
            if (!r.out_of_range) held_dist = raw;
            r.held_distance = held_dist;
            r.raw_distance  = raw;
            expected_frames.push_back(r);
            pending++;
          end
        end
      end
      default: begin
        if (b == HEADER_BYTE) begin
          sum_acc     = b;
          parse_phase = PH_HUNT2;
        end else begin
          parse_phase = PH_HUNT1;
        end
      end
    endcase
  endtask

  task automatic check_result();
    lfp_result_t r;
    if (expected_frames.size() == 0) begin
      $error("Result with no frame expected: held %0d raw %0d oor %0d",
             out_held_distance, out_raw_distance, out_out_of_range);
      errors++;
    end else begin
      r = expected_frames.pop_front();
      pending--;
      if (out_held_distance !== r.held_distance) begin
        $error("held_distance: expected %0d, actual %0d", r.held_distance, out_held_distance);
        errors++;
      end
      if (out_raw_distance !== r.raw_distance) begin
        $error("raw_distance: expected %0d, actual %0d", r.raw_distance, out_raw_distance);
        errors++;
      end
      if (out_out_of_range !== r.out_of_range) begin
        $error("out_of_range: expected %0d, actual %0d", r.out_of_range, out_out_of_range);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      parse_phase = PH_HUNT1;
      body_cnt    = 3'd0;
      sum_acc     = 8'd0;
      dist_lo     = 8'd0;
      dist_hi     = 8'd0;
      held_dist   = 16'd0;
      limit_reg   = LIMIT_RESET;
    end else begin
      if (cfg_wr_en) limit_reg = cfg_wr_data;
      if (in_valid && !in_stall) parse_byte(in_rx_byte);
      if (out_valid && !out_stall) check_result();
    end
  end

endmodule

FILE: dv/tb_lidar_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lidar_frame_parser
// Testbench for the lidar frame parser. It sends directed and random serial
// byte streams, mostly well-formed frames with random content, under several
// range limits, with random gaps on the byte side and random stalls on the
// result side. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lidar_frame_parser;
  import lfp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_BYTES  = 220;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_held_distance;
  logic [15:0] out_raw_distance;
  logic        out_out_of_range;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  int          errors;
  int          pending;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          calm_left = 0;
  logic [15:0] cur_limit = LIMIT_RESET;
  bit          random_phase = 1'b0;
  logic [15:0] limit_plan [6] = '{16'd0, 16'hFFFF, 16'd1, 16'd0, LIMIT_RESET, 16'd300};

  always #10 clk = ~clk;

  lidar_frame_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_held_distance (out_held_distance),
    .out_raw_distance  (out_raw_distance),
    .out_out_of_range  (out_out_of_range),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data)
  );

  lfp_frame_checker frame_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_held_distance (out_held_distance),
    .out_raw_distance  (out_raw_distance),
    .out_out_of_range  (out_out_of_range),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .errors            (errors),
    .pending           (pending)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int r;
    int gap;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    r = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      gap = 0;
    end else if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      gap = 0;
    end else if (r < 60) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 3);
    end else if (r < 98) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [15:0] dist_val, input logic [31:0] extra,
                            input bit corrupt);
    logic [7:0] body [6];
    logic [7:0] cs;
    body = '{dist_val[7:0], dist_val[15:8], extra[7:0], extra[15:8], extra[23:16],
             extra[31:24]};
    cs = HEADER_BYTE + HEADER_BYTE;
    send_byte(HEADER_BYTE);
    send_byte(HEADER_BYTE);
    foreach (body[i]) begin
      cs = cs + body[i];
      send_byte(body[i]);
    end
    if (corrupt) cs = cs ^ 8'($urandom_range(1, 255));
    send_byte(cs);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_range_limit(input logic [15:0] value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_limit = value;
  endtask

  task automatic random_stream(input int count);
    int target;
    int r;
    logic [15:0] frame_dist;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 78) begin
        case ($urandom_range(0, 5))
          0: frame_dist = cur_limit;
          1: frame_dist = cur_limit - 16'd1;
          2: frame_dist = 16'd0;
          3: frame_dist = 16'hFFFF;
          default: frame_dist = 16'($urandom_range(0, 65535));
        endcase
        send_frame(frame_dist, $urandom, $urandom_range(0, 9) == 0);
      end else if (r < 88) begin
        send_byte(HEADER_BYTE);
        if ($urandom_range(0, 1)) begin
          send_byte(HEADER_BYTE);
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_byte(8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte($urandom_range(0, 3) == 0 ? HEADER_BYTE : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    int r;
    int n;
    int rcv_cycles;
    bit held_long;
    rcv_cycles = 0;
    held_long  = 1'b0;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      if ((!held_long && random_phase && rcv_cycles >= 2000) ||
          $urandom_range(0, 399) == 0) begin
        n = $urandom_range(200, 400);
        out_stall <= 1'b1;
        held_long = 1'b1;
      end else if (r < 15) begin
        n = $urandom_range(30, 150);
        out_stall <= 1'b0;
      end else if (r < 55) begin
        n = $urandom_range(1, 4);
        out_stall <= 1'b0;
      end else if (r < 90) begin
        n = $urandom_range(1, 3);
        out_stall <= 1'b1;
      end else begin
        n = $urandom_range(5, 25);
        out_stall <= 1'b1;
      end
      repeat (n) @(posedge clk);
      rcv_cycles += n;
    end
  end

  initial begin
    logic [15:0] next_limit;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(HEADER_BYTE);
    send_byte(8'h00);
    send_frame(16'h5959, 32'hFF00_5959, 1'b0);
    send_frame(LIMIT_RESET - 16'd1, 32'hFFFF_FFFF, 1'b0);
    send_frame(16'h1234, 32'h0000_0000, 1'b1);

    random_phase <= 1'b1;
    random_stream(PHASE_BYTES);
    foreach (limit_plan[p]) begin
      next_limit = (p == 3) ? 16'($urandom_range(0, 65535)) : limit_plan[p];
      set_range_limit(next_limit);
      random_stream(PHASE_BYTES);
    end

    drain();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
